### hdl/upfa_pkg.sv
// shared constants, types and helpers of the unit phase pipeline
package upfa_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int GUARD_BITS    = 8;
  localparam int INT_BITS      = 8;
  localparam int ANGLE_W       = 17;
  localparam int OUT_W         = 16;
  localparam int HORNER_ORDER  = 6;
  localparam int NORM_STAGES   = 5;
  localparam int NM_W          = 30;
  localparam int SUM_W         = 2 * NM_W + 1;
  localparam int ROOT_W        = NM_W + 1;
  localparam int RECIP_EXTRA   = 3;

  localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct packed {
    logic zero;
    logic neg_r;
    logic neg_i;
  } upfa_side_t;

  // width of the horner terms, signed
  function automatic int p_width(input int frac_bits);
    return frac_bits + GUARD_BITS + INT_BITS;
  endfunction

  // accept to done strobe, in cycles
  function automatic int pipe_latency(input int frac_bits);
    return 3 * HORNER_ORDER + NORM_STAGES + ROOT_W + (frac_bits + 1) + 1;
  endfunction

  // saturate to the output field range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

### hdl/upfa_horner_step.sv
// one horner step p <- 1 + (i*a*p)/k in three register stages
module upfa_horner_step
  import upfa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int K = 1,
  localparam int P_W = p_width(FRAC_BITS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic signed [P_W-1:0]     in_re,
  input  logic signed [P_W-1:0]     in_im,
  output logic                      out_valid,
  output logic signed [ANGLE_W-1:0] out_angle,
  output logic signed [P_W-1:0]     out_re,
  output logic signed [P_W-1:0]     out_im
);

  localparam int WORK_W = FRAC_BITS + GUARD_BITS;
  localparam int PROD_W = ANGLE_W + P_W;
  localparam int MAG_W  = PROD_W - FRAC_BITS;
  localparam int N_W    = MAG_W + 1;
  localparam int SH     = N_W + RECIP_EXTRA;
  localparam int RW     = SH + 1;
  localparam int QF_W   = N_W + RW;
  localparam int Q_W    = QF_W - SH;
  // ceiling reciprocal, exact floor division for n below 2^N_W
  localparam logic [RW-1:0] RECIP =
    RW'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));
  localparam logic [N_W-1:0]    HALF_K     = N_W'(K / 2);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [P_W-1:0] ONE_W  = P_W'(1) << WORK_W;

  logic v1, v2, v3;
  logic signed [ANGLE_W-1:0] angle1, angle2, angle3;
  logic signed [PROD_W-1:0]  prod_r, prod_i;
  logic [QF_W-1:0]           qf_r, qf_i;
  logic                      neg_r, neg_i;
  logic signed [P_W-1:0]     re3, im3;

  logic [PROD_W-1:0] mag_r, mag_i, sum_r, sum_i;
  logic [N_W-1:0]    n_r, n_i;
  logic [QF_W-1:0]   qf_r_next, qf_i_next;
  logic [Q_W-1:0]    q_r, q_i;
  logic signed [P_W-1:0] qs_r, qs_i, re_next, im_next;

  // rounded shift on magnitudes, then divide by k through the reciprocal
  always_comb begin
    mag_r = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    mag_i = prod_i[PROD_W-1] ? PROD_W'(-prod_i) : PROD_W'(prod_i);
    sum_r = mag_r + ROUND_HALF;
    sum_i = mag_i + ROUND_HALF;
    n_r   = N_W'(sum_r[PROD_W-1:FRAC_BITS]) + HALF_K;
    n_i   = N_W'(sum_i[PROD_W-1:FRAC_BITS]) + HALF_K;
    qf_r_next = QF_W'(n_r) * QF_W'(RECIP);
    qf_i_next = QF_W'(n_i) * QF_W'(RECIP);
  end

  always_comb begin
    q_r  = qf_r[QF_W-1:SH];
    q_i  = qf_i[QF_W-1:SH];
    qs_r = P_W'(q_r);
    qs_i = P_W'(q_i);
    re_next = neg_r ? ONE_W - qs_r : ONE_W + qs_r;
    im_next = neg_i ? -qs_i : qs_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    angle1 <= in_angle;
    prod_r <= PROD_W'(in_angle) * PROD_W'(in_im);
    prod_i <= PROD_W'(in_angle) * PROD_W'(in_re);
    angle2 <= angle1;
    qf_r   <= qf_r_next;
    qf_i   <= qf_i_next;
    // real part takes the negated product since i*i = -1
    neg_r  <= ~prod_r[PROD_W-1];
    neg_i  <= prod_i[PROD_W-1];
    angle3 <= angle2;
    re3    <= re_next;
    im3    <= im_next;
  end

  assign out_valid = v3;
  assign out_angle = angle3;
  assign out_re    = re3;
  assign out_im    = im3;

endmodule

### hdl/upfa_normalize.sv
// magnitudes, scaling to a fixed window and sum of squares
module upfa_normalize
  import upfa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int P_W = p_width(FRAC_BITS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [P_W-1:0] in_re,
  input  logic signed [P_W-1:0] in_im,
  output logic                  out_valid,
  output logic [NM_W-1:0]       out_mr,
  output logic [NM_W-1:0]       out_mi,
  output logic [SUM_W-1:0]      out_sum,
  output upfa_side_t            out_side
);

  localparam int LEAD_W = $clog2(P_W + 1);
  localparam int WIDE_W = P_W + NM_W;

  logic v1, v2, v3, v4, v5;
  logic [P_W-1:0]  m1_r, m1_i, mx1, m2_r, m2_i;
  upfa_side_t      side1, side2, side3, side4, side5;
  logic [LEAD_W-1:0] shift2, shift_next;
  logic [NM_W-1:0] m3_r, m3_i, m4_r, m4_i, m5_r, m5_i;
  logic [2*NM_W-1:0] sq4_r, sq4_i;
  logic [SUM_W-1:0]  sum5;

  logic [P_W-1:0]    abs_r, abs_i;
  logic [WIDE_W-1:0] wide_r, wide_i;
  upfa_side_t        side_next;

  always_comb begin
    abs_r = in_re[P_W-1] ? P_W'(-in_re) : P_W'(in_re);
    abs_i = in_im[P_W-1] ? P_W'(-in_im) : P_W'(in_im);
    side_next.zero  = (in_re == '0) && (in_im == '0);
    side_next.neg_r = in_re[P_W-1];
    side_next.neg_i = in_im[P_W-1];
  end

  // one past the leading one of the larger magnitude
  always_comb begin
    shift_next = '0;
    for (int b = 0; b < P_W; b++) begin
      if (mx1[b]) begin
        shift_next = LEAD_W'(b + 1);
      end
    end
  end

  // leading one lands on the top bit of the window, low bits truncate
  always_comb begin
    wide_r = {m2_r, NM_W'(0)} >> shift2;
    wide_i = {m2_i, NM_W'(0)} >> shift2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    m1_r  <= abs_r;
    m1_i  <= abs_i;
    mx1   <= (abs_r > abs_i) ? abs_r : abs_i;
    side1 <= side_next;
    m2_r   <= m1_r;
    m2_i   <= m1_i;
    shift2 <= shift_next;
    side2  <= side1;
    m3_r  <= wide_r[NM_W-1:0];
    m3_i  <= wide_i[NM_W-1:0];
    side3 <= side2;
    sq4_r <= (2*NM_W)'(m3_r) * (2*NM_W)'(m3_r);
    sq4_i <= (2*NM_W)'(m3_i) * (2*NM_W)'(m3_i);
    m4_r  <= m3_r;
    m4_i  <= m3_i;
    side4 <= side3;
    sum5  <= SUM_W'(sq4_r) + SUM_W'(sq4_i);
    m5_r  <= m4_r;
    m5_i  <= m4_i;
    side5 <= side4;
  end

  assign out_valid = v5;
  assign out_mr    = m5_r;
  assign out_mi    = m5_i;
  assign out_sum   = sum5;
  assign out_side  = side5;

endmodule

### hdl/upfa_isqrt.sv
// pipelined floor square root, one result bit per stage
module upfa_isqrt
  import upfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  logic [NM_W-1:0]   in_mr,
  input  logic [NM_W-1:0]   in_mi,
  input  upfa_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [NM_W-1:0]   out_mr,
  output logic [NM_W-1:0]   out_mi,
  output upfa_side_t        out_side
);

  localparam int STEPS = ROOT_W;
  localparam int RT_W  = SUM_W + 1;

  logic             vld  [1:STEPS];
  logic [SUM_W-1:0] rem  [1:STEPS];
  logic [RT_W-1:0]  root [1:STEPS];
  logic [NM_W-1:0]  mr   [1:STEPS];
  logic [NM_W-1:0]  mi   [1:STEPS];
  upfa_side_t       side [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (STEPS - 1 - i));

    logic             v_in;
    logic [SUM_W-1:0] rem_in;
    logic [RT_W-1:0]  root_in;
    logic [NM_W-1:0]  mr_in, mi_in;
    upfa_side_t       side_in;
    logic [RT_W-1:0]  trial;
    logic             take;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_sum;
      assign root_in = '0;
      assign mr_in   = in_mr;
      assign mi_in   = in_mi;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = vld[i];
      assign rem_in  = rem[i];
      assign root_in = root[i];
      assign mr_in   = mr[i];
      assign mi_in   = mi[i];
      assign side_in = side[i];
    end

    assign trial = root_in + BIT;
    assign take  = RT_W'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_in;
      end
      rem[i+1]  <= take ? SUM_W'(RT_W'(rem_in) - trial) : rem_in;
      root[i+1] <= take ? (root_in >> 1) + BIT : root_in >> 1;
      mr[i+1]   <= mr_in;
      mi[i+1]   <= mi_in;
      side[i+1] <= side_in;
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = root[STEPS][ROOT_W-1:0];
  assign out_mr    = mr[STEPS];
  assign out_mi    = mi[STEPS];
  assign out_side  = side[STEPS];

endmodule

### hdl/upfa_divide.sv
// restoring division of both parts by the root, then sign and saturation
module upfa_divide
  import upfa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [NM_W-1:0]         in_mr,
  input  logic [NM_W-1:0]         in_mi,
  input  logic [ROOT_W-1:0]       in_root,
  input  upfa_side_t              in_side,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_re,
  output logic signed [OUT_W-1:0] out_im
);

  localparam int QB    = FRAC_BITS + 1;
  localparam int NUM_W = NM_W + FRAC_BITS + 2;
  localparam int D_W   = ROOT_W + 1;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

  logic             vld   [1:QB];
  logic [NUM_W-1:0] rem_r [1:QB];
  logic [NUM_W-1:0] rem_i [1:QB];
  logic [QB-1:0]    q_r   [1:QB];
  logic [QB-1:0]    q_i   [1:QB];
  logic [D_W-1:0]   den   [1:QB];
  upfa_side_t       side  [1:QB];

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int S = QB - 1 - i;

    logic             v_in;
    logic [NUM_W-1:0] rr_in, ri_in, dsh;
    logic [QB-1:0]    qr_in, qi_in;
    logic [D_W-1:0]   d_in;
    upfa_side_t       side_in;
    logic             take_r, take_i;

    if (i == 0) begin : g_first
      // numerator carries half the divisor for round to nearest
      assign v_in    = in_valid;
      assign rr_in   = (NUM_W'(in_mr) << (FRAC_BITS + 1)) + NUM_W'(in_root);
      assign ri_in   = (NUM_W'(in_mi) << (FRAC_BITS + 1)) + NUM_W'(in_root);
      assign qr_in   = '0;
      assign qi_in   = '0;
      assign d_in    = {in_root, 1'b0};
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = vld[i];
      assign rr_in   = rem_r[i];
      assign ri_in   = rem_i[i];
      assign qr_in   = q_r[i];
      assign qi_in   = q_i[i];
      assign d_in    = den[i];
      assign side_in = side[i];
    end

    assign dsh    = NUM_W'(d_in) << S;
    assign take_r = rr_in >= dsh;
    assign take_i = ri_in >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_in;
      end
      rem_r[i+1] <= take_r ? rr_in - dsh : rr_in;
      rem_i[i+1] <= take_i ? ri_in - dsh : ri_in;
      q_r[i+1]   <= take_r ? qr_in | (QB'(1) << S) : qr_in;
      q_i[i+1]   <= take_i ? qi_in | (QB'(1) << S) : qi_in;
      den[i+1]   <= d_in;
      side[i+1]  <= side_in;
    end
  end

  logic [QB-1:0]           mag_r, mag_i;
  logic signed [63:0]      val_r, val_i;
  logic signed [OUT_W-1:0] re_next, im_next;
  logic                    done_q;
  logic signed [OUT_W-1:0] re_q, im_q;

  always_comb begin
    mag_r = (q_r[QB] > ONE_Q) ? ONE_Q : q_r[QB];
    mag_i = (q_i[QB] > ONE_Q) ? ONE_Q : q_i[QB];
    val_r = side[QB].neg_r ? -$signed(64'(mag_r)) : $signed(64'(mag_r));
    val_i = side[QB].neg_i ? -$signed(64'(mag_i)) : $signed(64'(mag_i));
    if (side[QB].zero) begin
      // zero magnitude maps to plus one
      re_next = sat_out($signed(64'(ONE_Q)));
      im_next = '0;
    end else begin
      re_next = sat_out(val_r);
      im_next = sat_out(val_i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[QB];
    end
    re_q <= re_next;
    im_q <= im_next;
  end

  assign out_valid = done_q;
  assign out_re    = re_q;
  assign out_im    = im_q;

endmodule

### hdl/unit_phase_from_angle_unit.sv
// top level: angle to unit-length complex phase, fully pipelined
// throughput: one transfer per cycle, busy is low whenever rst is low
// stages: 18 for the six horner steps, 5 normalize, 31 square root,
//   FRAC_BITS + 1 division, 1 output register
// reset: synchronous rst clears all valid bits, nothing in flight survives it
module unit_phase_from_angle_unit
  import upfa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int P_W = p_width(FRAC_BITS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] phase_angle,
  output logic                      done,
  output logic signed [OUT_W-1:0]   phase_real,
  output logic signed [OUT_W-1:0]   phase_imag
);

  // horner constant 1.0 at the working precision
  localparam logic signed [P_W-1:0] ONE_W = P_W'(1) << (FRAC_BITS + GUARD_BITS);

  // the pipeline never stalls, so only reset holds off a transfer
  assign busy = rst;

  // horner chain, step i divides by HORNER_ORDER - i
  wire                      hv  [0:HORNER_ORDER];
  wire signed [ANGLE_W-1:0] ha  [0:HORNER_ORDER-1];
  wire signed [P_W-1:0]     hre [0:HORNER_ORDER];
  wire signed [P_W-1:0]     him [0:HORNER_ORDER];

  assign hv[0]  = start & ~busy;
  assign ha[0]  = phase_angle;
  assign hre[0] = ONE_W;
  assign him[0] = '0;

  for (genvar i = 0; i < HORNER_ORDER; i++) begin : g_horner
    if (i < HORNER_ORDER - 1) begin : g_mid
      upfa_horner_step #(
        .FRAC_BITS(FRAC_BITS),
        .K        (HORNER_ORDER - i)
      ) u_step (
        .clk      (clk),
        .rst      (rst),
        .in_valid (hv[i]),
        .in_angle (ha[i]),
        .in_re    (hre[i]),
        .in_im    (him[i]),
        .out_valid(hv[i+1]),
        .out_angle(ha[i+1]),
        .out_re   (hre[i+1]),
        .out_im   (him[i+1])
      );
    end else begin : g_last
      // last step has k = 1, the angle ends here
      upfa_horner_step #(
        .FRAC_BITS(FRAC_BITS),
        .K        (HORNER_ORDER - i)
      ) u_step (
        .clk      (clk),
        .rst      (rst),
        .in_valid (hv[i]),
        .in_angle (ha[i]),
        .in_re    (hre[i]),
        .in_im    (him[i]),
        .out_valid(hv[i+1]),
        .out_angle(),
        .out_re   (hre[i+1]),
        .out_im   (him[i+1])
      );
    end
  end

  // scale both parts into a fixed window and form the squared magnitude
  logic              nv;
  logic [NM_W-1:0]   n_mr, n_mi;
  logic [SUM_W-1:0]  n_sum;
  upfa_side_t        n_side;

  upfa_normalize #(
    .FRAC_BITS(FRAC_BITS)
  ) u_normalize (
    .clk      (clk),
    .rst      (rst),
    .in_valid (hv[HORNER_ORDER]),
    .in_re    (hre[HORNER_ORDER]),
    .in_im    (him[HORNER_ORDER]),
    .out_valid(nv),
    .out_mr   (n_mr),
    .out_mi   (n_mi),
    .out_sum  (n_sum),
    .out_side (n_side)
  );

  // magnitude as floor square root
  logic              sv;
  logic [ROOT_W-1:0] s_root;
  logic [NM_W-1:0]   s_mr, s_mi;
  upfa_side_t        s_side;

  upfa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (nv),
    .in_sum   (n_sum),
    .in_mr    (n_mr),
    .in_mi    (n_mi),
    .in_side  (n_side),
    .out_valid(sv),
    .out_root (s_root),
    .out_mr   (s_mr),
    .out_mi   (s_mi),
    .out_side (s_side)
  );

  // part over magnitude, signs restored, outputs registered
  upfa_divide #(
    .FRAC_BITS(FRAC_BITS)
  ) u_divide (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sv),
    .in_mr    (s_mr),
    .in_mi    (s_mi),
    .in_root  (s_root),
    .in_side  (s_side),
    .out_valid(done),
    .out_re   (phase_real),
    .out_im   (phase_imag)
  );

endmodule

### hdl/upfa_checker.sv
// port-level checks on the unit phase pipeline and their bind
module upfa_checker
  import upfa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic signed [ANGLE_W-1:0] phase_angle,
  input logic                      done,
  input logic signed [OUT_W-1:0]   phase_real,
  input logic signed [OUT_W-1:0]   phase_imag
);

  localparam int     LATENCY = pipe_latency(FRAC_BITS);
  localparam longint ONE     = longint'(1) << FRAC_BITS;
  localparam longint HI      = (ONE > OUT_MAX) ? OUT_MAX : ONE;
  localparam longint LO      = (-ONE < OUT_MIN) ? OUT_MIN : -ONE;

  // every transfer gives a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transfer gave no result");

  // every result goes back to an accepted transfer
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without accepted transfer");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (longint'(phase_real) <= HI) && (longint'(phase_real) >= LO) &&
             (longint'(phase_imag) <= HI) && (longint'(phase_imag) >= LO))
    else $error("result outside unit range");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && (phase_angle == '0), LATENCY) |->
      (longint'(phase_real) == HI) && (phase_imag == '0))
    else $error("zero angle not mapped to plus one");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (phase_real != '0) || (phase_imag != '0))
    else $error("result has zero length");

endmodule

bind unit_phase_from_angle_unit upfa_checker #(.FRAC_BITS(FRAC_BITS)) u_upfa_checker (.*);
